@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define SGAI_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sgai assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define SGAI_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sgai assertion failed");

`endif

@@ rtl/sgai_pkg.sv @@
// Types shared by the grid area index controller, datapath and top level.
package sgai_pkg;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_QUERY  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   localparam logic [10:0] CELLS_RESET = 11'd1024;

   typedef struct packed {
      logic load;       // latch accepted item, start bounds and query reads
      logic walk_init;  // set walk index to a range start
      logic walk_new;   // range source: new bounds (1) or stored bounds (0)
      logic walk_row;   // range axis: rows (1) or columns (0)
      logic step;       // advance walk index
      logic rd;         // read mask memory at walk index
      logic wr_clr;     // write back read mask with area bit cleared
      logic wr_set;     // write back read mask with area bit set
      logic bnd_wr;     // store new bounds, mark valid
      logic vld_clr;    // mark stored bounds invalid
      logic clr;        // clear sweep step
      logic mask_load;  // load query hit mask
      logic emit;       // push one result into output register
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     area_ok;
      logic     old_valid;
      logic     reject;
      logic     axis_row;
      logic     walk_end;
      logic     clr_end;
      logic     out_free;
      logic     emit_last;
   } sta_type;

endpackage

@@ rtl/sgai_ctrl.sv @@
// Controller state machine of the grid area index.
module sgai_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sgai_pkg::sta_type sta,
   output sgai_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOOK  = 9'b000000010,
      ST_RM_RD = 9'b000000100,
      ST_RM_WR = 9'b000001000,
      ST_AD_RD = 9'b000010000,
      ST_AD_WR = 9'b000100000,
      ST_CLEAR = 9'b001000000,
      ST_EMIT  = 9'b010000000,
      ST_SPARE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      do_add;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign do_add    = (sta.func == sgai_pkg::FUNC_ADD) && !sta.reject;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            case (sta.func)
               sgai_pkg::FUNC_QUERY: begin
                  cmd.mask_load = 1'b1;
                  state_in      = ST_EMIT;
               end
               sgai_pkg::FUNC_CLEAR: state_in = ST_CLEAR;
               default: begin
                  if (!sta.area_ok) begin
                     state_in = ST_IDLE;
                  end else if (sta.old_valid) begin
                     cmd.walk_init = 1'b1;
                     state_in      = ST_RM_RD;
                  end else if (do_add) begin
                     cmd.walk_init = 1'b1;
                     cmd.walk_new  = 1'b1;
                     state_in      = ST_AD_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_RM_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_RM_WR;
         end
         ST_RM_WR: begin
            cmd.wr_clr = 1'b1;
            if (!sta.walk_end) begin
               cmd.step = 1'b1;
               state_in = ST_RM_RD;
            end else if (!sta.axis_row) begin
               cmd.walk_init = 1'b1;
               cmd.walk_row  = 1'b1;
               state_in      = ST_RM_RD;
            end else begin
               cmd.vld_clr = 1'b1;
               if (do_add) begin
                  cmd.walk_init = 1'b1;
                  cmd.walk_new  = 1'b1;
                  state_in      = ST_AD_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_AD_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_AD_WR;
         end
         ST_AD_WR: begin
            cmd.wr_set = 1'b1;
            if (!sta.walk_end) begin
               cmd.step = 1'b1;
               state_in = ST_AD_RD;
            end else if (!sta.axis_row) begin
               cmd.walk_init = 1'b1;
               cmd.walk_new  = 1'b1;
               cmd.walk_row  = 1'b1;
               state_in      = ST_AD_RD;
            end else begin
               cmd.bnd_wr = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (sta.clr_end) state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (sta.out_free) begin
               cmd.emit = 1'b1;
               if (sta.emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

@@ rtl/sgai_datapath.sv @@
// Datapath of the grid area index: mask memories, bounds store, walker, result register.
module sgai_datapath #(
   parameter int GRID_CELLS = 1024,
   parameter int MAX_AREAS  = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_func,
   input  logic [5:0]          req_area_number,
   input  logic signed [15:0]  req_start_col,
   input  logic signed [15:0]  req_start_row,
   input  logic signed [15:0]  req_end_col,
   input  logic signed [15:0]  req_end_row,
   input  logic signed [15:0]  req_query_col,
   input  logic signed [15:0]  req_query_row,
   input  logic                csr_we,
   input  logic [10:0]         csr_data,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [5:0]          rsp_hit_area,
   output logic                rsp_hit_valid,
   output logic                rsp_outside_grid,
   output logic                rsp_last_hit,
   input  sgai_pkg::cmd_type   cmd,
   output sgai_pkg::sta_type   sta
);

   localparam int AW  = $clog2(GRID_CELLS);
   localparam int AIW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
   localparam int BW  = 4 * AW;
   localparam logic [AW-1:0] LAST_CELL = AW'(GRID_CELLS - 1);

   logic [10:0] cells_ff;
   int          n_v;
   int          sc_v, sr_v, ec_v, er_v, qc_v, qr_v;
   logic        reject_w, outside_w;

   sgai_pkg::func_type func_ff;
   logic [5:0]    area_ff;
   logic [AW-1:0] nsc_ff, nsr_ff, nec_ff, ner_ff;
   logic          reject_ff, outside_ff;
   logic [AW-1:0] idx_ff, idx_in;
   logic          row_ff, new_ff;
   logic [AW-1:0] osc, osr, oec, oer, wstart, wend;

   logic [MAX_AREAS-1:0] col_mem [GRID_CELLS];
   logic [MAX_AREAS-1:0] row_mem [GRID_CELLS];
   logic [MAX_AREAS-1:0] col_rd_ff, row_rd_ff;
   logic [AW-1:0]        col_raddr, row_raddr;
   logic                 mem_re, col_we, row_we;
   logic [MAX_AREAS-1:0] col_wdata, row_wdata, bit_w;

   logic [BW-1:0]        bnd_mem [MAX_AREAS];
   logic [BW-1:0]        bnd_rd_ff;
   logic [MAX_AREAS-1:0] valid_ff;
   logic [AIW-1:0]       aidx;

   logic [MAX_AREAS-1:0] mask_ff, low_w, rest_w;
   logic [5:0]           enc_w;
   logic                 rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)       cells_ff <= sgai_pkg::CELLS_RESET;
      else if (csr_we) cells_ff <= csr_data;
   end

   // Saturated cell count, clamping and range checks on the incoming item.
   always_comb begin
      n_v = int'(cells_ff);
      if (n_v < 1) n_v = 1;
      if (n_v > GRID_CELLS) n_v = GRID_CELLS;
      sc_v = int'(req_start_col);
      sr_v = int'(req_start_row);
      ec_v = int'(req_end_col);
      er_v = int'(req_end_row);
      qc_v = int'(req_query_col);
      qr_v = int'(req_query_row);
      reject_w  = (ec_v < 0) || (er_v < 0) || (sc_v >= n_v) || (sr_v >= n_v);
      outside_w = (qc_v < 0) || (qc_v >= n_v) || (qr_v < 0) || (qr_v >= n_v);
      if (sc_v < 0) sc_v = 0;
      if (sr_v < 0) sr_v = 0;
      if (ec_v > n_v - 1) ec_v = n_v - 1;
      if (er_v > n_v - 1) er_v = n_v - 1;
      if ((sc_v > ec_v) || (sr_v > er_v)) reject_w = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= sgai_pkg::func_type'(req_func);
         area_ff    <= req_area_number;
         nsc_ff     <= sc_v[AW-1:0];
         nsr_ff     <= sr_v[AW-1:0];
         nec_ff     <= ec_v[AW-1:0];
         ner_ff     <= er_v[AW-1:0];
         reject_ff  <= reject_w;
         outside_ff <= outside_w;
      end
   end

   assign aidx = area_ff[AIW-1:0];
   assign {osc, oec, osr, oer} = bnd_rd_ff;
   assign bit_w = MAX_AREAS'(1) << aidx;

   always_comb begin
      case ({cmd.walk_new, cmd.walk_row})
         2'b00:   wstart = osc;
         2'b01:   wstart = osr;
         2'b10:   wstart = nsc_ff;
         default: wstart = nsr_ff;
      endcase
      case ({new_ff, row_ff})
         2'b00:   wend = oec;
         2'b01:   wend = oer;
         2'b10:   wend = nec_ff;
         default: wend = ner_ff;
      endcase
      idx_in = idx_ff;
      if (cmd.load)                 idx_in = '0;
      else if (cmd.walk_init)       idx_in = wstart;
      else if (cmd.step || cmd.clr) idx_in = idx_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         row_ff <= 1'b0;
         new_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (cmd.walk_init) begin
            row_ff <= cmd.walk_row;
            new_ff <= cmd.walk_new;
         end
      end
   end

   assign mem_re    = cmd.load || cmd.rd;
   assign col_raddr = cmd.load ? req_query_col[AW-1:0] : idx_ff;
   assign row_raddr = cmd.load ? req_query_row[AW-1:0] : idx_ff;
   assign col_we    = cmd.clr || ((cmd.wr_clr || cmd.wr_set) && !row_ff);
   assign row_we    = cmd.clr || ((cmd.wr_clr || cmd.wr_set) && row_ff);
   assign col_wdata = cmd.clr ? '0 : (cmd.wr_set ? (col_rd_ff | bit_w) : (col_rd_ff & ~bit_w));
   assign row_wdata = cmd.clr ? '0 : (cmd.wr_set ? (row_rd_ff | bit_w) : (row_rd_ff & ~bit_w));

   always_ff @(posedge clock) begin
      if (col_we) col_mem[idx_ff] <= col_wdata;
      if (mem_re) col_rd_ff <= col_mem[col_raddr];
   end

   always_ff @(posedge clock) begin
      if (row_we) row_mem[idx_ff] <= row_wdata;
      if (mem_re) row_rd_ff <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.bnd_wr) bnd_mem[aidx] <= {nsc_ff, nec_ff, nsr_ff, ner_ff};
      if (cmd.load)   bnd_rd_ff <= bnd_mem[req_area_number[AIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr) valid_ff <= '0;
      else if (cmd.bnd_wr)  valid_ff[aidx] <= 1'b1;
      else if (cmd.vld_clr) valid_ff[aidx] <= 1'b0;
   end

   // Lowest set bit of the remaining hit mask.
   always_comb begin
      low_w  = mask_ff & (~mask_ff + MAX_AREAS'(1));
      rest_w = mask_ff & ~low_w;
      enc_w  = '0;
      for (int i = 0; i < MAX_AREAS; i++) begin
         if (low_w[i]) enc_w = enc_w | 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mask_load)  mask_ff <= outside_ff ? '0 : (col_rd_ff & row_rd_ff);
      else if (cmd.emit)  mask_ff <= rest_w;
   end

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (cmd.emit)  rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_hit_area     <= (mask_ff == '0) ? 6'd0 : enc_w;
         rsp_hit_valid    <= (mask_ff != '0);
         rsp_outside_grid <= outside_ff;
         rsp_last_hit     <= (rest_w == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sta.func      = func_ff;
   assign sta.area_ok   = ({1'b0, area_ff} < 7'(MAX_AREAS));
   assign sta.old_valid = valid_ff[aidx];
   assign sta.reject    = reject_ff;
   assign sta.axis_row  = row_ff;
   assign sta.walk_end  = (idx_ff == wend);
   assign sta.clr_end   = (idx_ff == LAST_CELL);
   assign sta.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sta.emit_last = (rest_w == '0);

endmodule

@@ rtl/separable_grid_area_index_unit.sv @@
// Top level of the separable grid area index.
//
// Request channel (req_*): one operation per transfer: add area, remove area,
// query cell, clear all. req_stall is high while an operation is in progress.
// Response channel (rsp_*): query results only, one per transfer, ascending
// area order, rsp_last_hit on the final one; an empty or off-grid query gives
// a single result with rsp_hit_valid low.
// Config channel (csr_*): cells-in-use register, always ready; write it idle.
// Add and remove walk each column and row entry (stored range, then new
// range) with a read-modify-write of the mask memories; a query emits its
// results in turn while the output register is free; clear all sweeps all
// GRID_CELLS entries. After reset the mask memories are cleared by the same
// sweep with req_stall high. A stalled result holds in the output register;
// the query walk waits for it.
module separable_grid_area_index_unit #(
   parameter int GRID_CELLS = 1024,
   parameter int MAX_AREAS  = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_area_number,
   input  logic signed [15:0] req_start_col,
   input  logic signed [15:0] req_start_row,
   input  logic signed [15:0] req_end_col,
   input  logic signed [15:0] req_end_row,
   input  logic signed [15:0] req_query_col,
   input  logic signed [15:0] req_query_row,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_hit_area,
   output logic               rsp_hit_valid,
   output logic               rsp_outside_grid,
   output logic               rsp_last_hit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [10:0]        csr_data
);

   `include "assert_macros.svh"

   sgai_pkg::cmd_type cmd;
   sgai_pkg::sta_type sta;

   assign csr_ready = 1'b1;

   sgai_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sta       (sta),
      .cmd       (cmd)
   );

   sgai_datapath #(
      .GRID_CELLS (GRID_CELLS),
      .MAX_AREAS  (MAX_AREAS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_area_number  (req_area_number),
      .req_start_col    (req_start_col),
      .req_start_row    (req_start_row),
      .req_end_col      (req_end_col),
      .req_end_row      (req_end_row),
      .req_query_col    (req_query_col),
      .req_query_row    (req_query_row),
      .csr_we           (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_hit_area     (rsp_hit_area),
      .rsp_hit_valid    (rsp_hit_valid),
      .rsp_outside_grid (rsp_outside_grid),
      .rsp_last_hit     (rsp_last_hit),
      .cmd              (cmd),
      .sta              (sta)
   );

   `SGAI_ASSERT_NXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   `SGAI_ASSERT_IMP(a_emit_room, cmd.emit, sta.out_free)
   `SGAI_ASSERT_IMP(a_sweep_after_reset, $fell(reset), req_stall)
   `SGAI_ASSERT_IMP(a_one_write, cmd.wr_clr, !cmd.wr_set && !cmd.clr)

endmodule
